@@ rtl/codel_pkg.sv @@
// Package for the CoDel drop decision block.
// Holds the sequencer state codes, operation modes and register indexes.
// No dependencies.
package codel_pkg;

    // Configuration register indexes on the write port.
    localparam logic [1:0] CFG_TARGET   = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MIN      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] TARGET_RST   = 32'd5000;
    localparam logic [27:0] INTERVAL_RST = 28'd100000;
    localparam logic [31:0] MIN_RST      = 32'd1514;

    // Reciprocal square root of one in Q0.16.
    localparam logic [15:0] INV_ONE = 16'hFFFF;

    // Phase codes: why the next transaction is expected.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DROP  = 2'd1;
    localparam logic [1:0] PH_ENTRY = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_N1,
        S_N2,
        S_N3,
        S_N4,
        S_N5,
        S_N6,
        S_CLM,
        S_CLA,
        S_OUT
    } t_state;

    // What the sequencer does after a Newton step or control law.
    typedef enum logic [1:0] {
        M_DROP,
        M_ENTRY,
        M_FOLLOW
    } t_mode;

endpackage

@@ rtl/codel_drop_decision.sv @@
// CoDel drop decision for the head of a queue, top level.
// One shared 32x32 multiplier under a small sequencer; uses codel_pkg.
//
// Usage:
//   Slave channel (i_s_axis_*): one transaction per popped head packet or
//   per empty-queue event. tuser carries the kind (1 = queue was empty),
//   tdata carries now, sojourn time and queue bytes.
//   Master channel (o_m_axis_*): exactly one result per input transaction,
//   telling whether to drop the packet, the dropping state, the drop count
//   and the next scheduled drop time. After a drop the consumer pops the
//   next packet and presents it with the same time value.
//   Configuration: i_cfg_we writes i_cfg_wdata to the register selected by
//   i_cfg_addr (0 target, 1 interval, 2 min bytes); write only while idle.
// Timing: o_s_axis_tready is high only while the block is idle. After acceptance a
//   result becomes valid after an evaluation state, then at most one control law
//   (multiply and add) and at most one Newton step, all on the one shared
//   multiplier. The result then holds until taken, and the next transaction is
//   accepted in the cycle after that.
// Reset (synchronous, active low) clears the dropping state and loads the
//   default register values; the block is ready as soon as reset is released.
module codel_drop_decision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,  // now_us[31:0], sojourn_us[63:32], queue_bytes[95:64]
    input  logic        i_s_axis_tuser,  // kind[0]
    // Result transactions.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // drop[0], dropping[1], drop_count[33:2],
                                         // next_drop_us[65:34], zero pad[71:66]
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    import codel_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    logic [31:0] r_target, r_min_bytes;
    logic [27:0] r_interval;

    logic        r_kind;
    logic [31:0] r_now, r_soj, r_bytes;

    logic        r_dropping, n_dropping;
    logic [31:0] r_count, n_count;
    logic [31:0] r_last_count, n_last_count;
    logic [15:0] r_inv, n_inv;
    logic [31:0] r_first_above, n_first_above;
    logic [31:0] r_drop_next, n_drop_next;
    logic [1:0]  r_phase, n_phase;
    logic        r_drop, n_drop;

    logic [63:0] r_prod;
    logic [46:0] r_v, n_v;
    logic [47:0] r_lo;

    logic [31:0] mul_a, mul_b;

    // Sojourn test and first-above tracking.
    logic        soj_fail, ok;
    logic [31:0] fa_set, fa_new;
    // Count reuse on re-entry.
    logic [31:0] cnt_diff, since_drop;
    logic [31:0] interval_x16;
    logic        reuse;
    // Newton and control law intermediates.
    logic [48:0] nt_diff;
    logic [47:0] nt_sum;
    logic [31:0] cl_base, cl_next;
    // Branch decisions for the sequencer.
    logic        go_newton, go_cl, go_out;

    // Sojourn test: fail clears first_above, first pass arms it.
    always_comb begin
        interval_x16 = {r_interval, 4'b0000};
        soj_fail     = r_kind | ((r_soj - r_target) >> 31 != 32'd0) | (r_bytes <= r_min_bytes);
        fa_set       = r_now + {4'b0000, r_interval};
        ok           = !soj_fail && (r_first_above != 32'd0) && (r_first_above - r_now) >> 31 != 32'd0;
        if (soj_fail) begin
            fa_new = 32'd0;
        end else if (r_first_above == 32'd0) begin
            fa_new = fa_set;
        end else begin
            fa_new = r_first_above;
        end
        cnt_diff   = r_count - r_last_count;
        since_drop = r_now - r_drop_next;
        reuse      = (cnt_diff > 32'd1) && !cnt_diff[31] && ((since_drop - interval_x16) >> 31 != 32'd0);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_N1: begin
                mul_a = {16'd0, r_inv};
                mul_b = {16'd0, r_inv};
            end
            S_N2: begin
                mul_a = r_count;
                mul_b = r_prod[31:0];
            end
            S_N4: begin
                mul_a = r_v[31:0];
                mul_b = {16'd0, r_inv};
            end
            S_N5: begin
                mul_a = {17'd0, r_v[46:32]};
                mul_b = {16'd0, r_inv};
            end
            S_CLM: begin
                mul_a = {4'd0, r_interval};
                mul_b = {16'd0, r_inv};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Datapath next values and branch decisions.
    always_comb begin
        n_mode        = r_mode;
        n_dropping    = r_dropping;
        n_count       = r_count;
        n_last_count  = r_last_count;
        n_inv         = r_inv;
        n_first_above = r_first_above;
        n_drop_next   = r_drop_next;
        n_phase       = r_phase;
        n_drop        = r_drop;
        n_v           = r_v;
        go_newton     = 1'b0;
        go_cl         = 1'b0;
        go_out        = 1'b0;

        nt_diff = {17'd3, 32'd0} - r_prod[48:0];
        nt_sum  = r_lo + {r_prod[15:0], 32'd0};
        cl_base = (r_mode == M_ENTRY) ? r_now : r_drop_next;
        cl_next = cl_base + r_prod[47:16];

        case (r_state)
            S_IDLE: begin
                n_drop = 1'b0;
            end
            S_EVAL: begin
                n_phase = PH_IDLE;
                go_out  = 1'b1;
                if (r_phase == PH_DROP) begin
                    n_first_above = fa_new;
                    if (!ok) begin
                        n_dropping = 1'b0;
                    end else begin
                        n_mode = M_FOLLOW;
                        go_out = 1'b0;
                        go_cl  = 1'b1;
                    end
                end else if (r_phase == PH_ENTRY) begin
                    n_first_above = fa_new;
                end else if (r_kind) begin
                    n_dropping = 1'b0;
                end else begin
                    n_first_above = fa_new;
                    if (r_dropping) begin
                        if (!ok) begin
                            n_dropping = 1'b0;
                        end else if ((r_now - r_drop_next) >> 31 == 32'd0) begin
                            n_count   = r_count + 32'd1;
                            n_drop    = 1'b1;
                            n_phase   = PH_DROP;
                            n_mode    = M_DROP;
                            go_out    = 1'b0;
                            go_newton = 1'b1;
                        end
                    end else if (ok) begin
                        n_drop     = 1'b1;
                        n_phase    = PH_ENTRY;
                        n_dropping = 1'b1;
                        n_mode     = M_ENTRY;
                        go_out     = 1'b0;
                        if (reuse) begin
                            n_count      = cnt_diff;
                            n_last_count = cnt_diff;
                            go_newton    = 1'b1;
                        end else begin
                            n_count      = 32'd1;
                            n_last_count = 32'd1;
                            n_inv        = INV_ONE;
                            go_cl        = 1'b1;
                        end
                    end
                end
            end
            S_N3: begin
                n_v = nt_diff[48:2];
            end
            S_N6: begin
                n_inv = nt_sum[46:31];
                if (r_mode == M_ENTRY) begin
                    go_cl = 1'b1;
                end else begin
                    go_out = 1'b1;
                end
            end
            S_CLA: begin
                n_drop_next = cl_next;
                go_out      = 1'b1;
                if (r_mode == M_FOLLOW && (r_now - cl_next) >> 31 == 32'd0) begin
                    n_count   = r_count + 32'd1;
                    n_drop    = 1'b1;
                    n_phase   = PH_DROP;
                    n_mode    = M_DROP;
                    go_out    = 1'b0;
                    go_newton = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = (i_s_axis_tvalid) ? S_EVAL : S_IDLE;
            S_N1:    n_state = S_N2;
            S_N2:    n_state = S_N3;
            S_N3:    n_state = S_N4;
            S_N4:    n_state = S_N5;
            S_N5:    n_state = S_N6;
            S_CLM:   n_state = S_CLA;
            S_OUT:   n_state = (i_m_axis_tready) ? S_IDLE : S_OUT;
            S_EVAL, S_N6, S_CLA: begin
                if (go_newton) begin
                    n_state = S_N1;
                end else if (go_cl) begin
                    n_state = S_CLM;
                end else if (go_out) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = (r_state == S_OUT);
        o_m_axis_tdata  = {6'd0, r_drop_next, r_count, r_dropping, r_drop};
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= M_DROP;
            r_target      <= TARGET_RST;
            r_interval    <= INTERVAL_RST;
            r_min_bytes   <= MIN_RST;
            r_dropping    <= 1'b0;
            r_count       <= 32'd0;
            r_last_count  <= 32'd0;
            r_inv         <= INV_ONE;
            r_first_above <= 32'd0;
            r_drop_next   <= 32'd0;
            r_phase       <= PH_IDLE;
            r_drop        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_dropping    <= n_dropping;
            r_count       <= n_count;
            r_last_count  <= n_last_count;
            r_inv         <= n_inv;
            r_first_above <= n_first_above;
            r_drop_next   <= n_drop_next;
            r_phase       <= n_phase;
            r_drop        <= n_drop;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TARGET:   r_target    <= i_cfg_wdata;
                    CFG_INTERVAL: r_interval  <= i_cfg_wdata[27:0];
                    CFG_MIN:      r_min_bytes <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: input capture and multiplier results.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_kind  <= i_s_axis_tuser;
            r_now   <= i_s_axis_tdata[31:0];
            r_soj   <= i_s_axis_tdata[63:32];
            r_bytes <= i_s_axis_tdata[95:64];
        end
        r_prod <= mul_a * mul_b;
        r_v    <= n_v;
        if (r_state == S_N5) begin
            r_lo <= r_prod[47:0];
        end
    end

endmodule
